// ----- hdl/ecd_pkg.sv -----
// Shared types and constants for the epoch to civil date/time converter.
package ecd_pkg;

    // Payload field types
    typedef logic signed [39:0] t_epoch;
    typedef logic signed [15:0] t_year;
    typedef logic        [3:0]  t_month;
    typedef logic        [4:0]  t_mday;
    typedef logic        [4:0]  t_hour;
    typedef logic        [5:0]  t_minute;
    typedef logic        [5:0]  t_second;

    // Calendar constants
    localparam longint unsigned SEC_DAY_HI  = 675;      // 86400 >> 7
    localparam longint unsigned ERA_DAYS    = 146097;   // days in 400 years
    localparam longint unsigned CIVIL_SHIFT = 719468;   // 0000-03-01 to 1970-01-01
    localparam longint unsigned YEAR_DAYS   = 365;
    localparam longint unsigned SEC_HOUR    = 3600;
    localparam longint unsigned SEC_MIN     = 60;

    // Bias on the day count so the seconds division only sees positive values
    localparam longint unsigned BIAS_DAYS   = 6362915;
    localparam logic [33:0]     DAY_BIAS    = 34'(BIAS_DAYS * SEC_DAY_HI);
    // Whole eras added so the era division only sees positive values
    localparam longint unsigned ERA_BIAS    = 39;
    localparam logic [24:0]     Z_BIAS      =
        25'(ERA_BIAS * ERA_DAYS + CIVIL_SHIFT - BIAS_DAYS);
    localparam logic [16:0]     YEAR_BIAS   = 17'(ERA_BIAS * 400);

    // Reciprocal multipliers: q = (x * MUL) >> SH, exact over the input width
    localparam int          HI_DIV_SH   = 27;   // 17-bit numerator / 675
    localparam logic [17:0] HI_DIV_MUL  =
        18'(((64'd1 << HI_DIV_SH) + SEC_DAY_HI - 1) / SEC_DAY_HI);
    localparam int          LO_DIV_SH   = 37;   // 27-bit numerator / 675
    localparam logic [27:0] LO_DIV_MUL  =
        28'(((64'd1 << LO_DIV_SH) + SEC_DAY_HI - 1) / SEC_DAY_HI);
    localparam int          ERA_DIV_SH  = 43;   // 25-bit numerator / 146097
    localparam logic [25:0] ERA_DIV_MUL =
        26'(((64'd1 << ERA_DIV_SH) + ERA_DAYS - 1) / ERA_DAYS);
    localparam int          HR_DIV_SH   = 29;   // 17-bit numerator / 3600
    localparam logic [17:0] HR_DIV_MUL  =
        18'(((64'd1 << HR_DIV_SH) + SEC_HOUR - 1) / SEC_HOUR);
    localparam int          MIN_DIV_SH  = 18;   // 12-bit numerator / 60
    localparam logic [12:0] MIN_DIV_MUL =
        13'(((64'd1 << MIN_DIV_SH) + SEC_MIN - 1) / SEC_MIN);
    localparam int          Q4Y_DIV_SH  = 29;   // 18-bit numerator / 1460
    localparam logic [18:0] Q4Y_DIV_MUL = 19'(((64'd1 << Q4Y_DIV_SH) + 1459) / 1460);
    localparam int          CEN_DIV_SH  = 34;   // 18-bit numerator / 36524
    localparam logic [18:0] CEN_DIV_MUL = 19'(((64'd1 << CEN_DIV_SH) + 36523) / 36524);
    localparam int          YR_DIV_SH   = 27;   // 18-bit numerator / 365
    localparam logic [18:0] YR_DIV_MUL  =
        19'(((64'd1 << YR_DIV_SH) + YEAR_DAYS - 1) / YEAR_DAYS);
    localparam int          C100_DIV_SH = 16;   // 9-bit numerator / 100
    localparam logic [9:0]  C100_DIV_MUL = 10'(((64'd1 << C100_DIV_SH) + 99) / 100);
    localparam int          MP_DIV_SH   = 19;   // 11-bit numerator / 153
    localparam logic [11:0] MP_DIV_MUL  = 12'(((64'd1 << MP_DIV_SH) + 152) / 153);

    // Day of the March-based year on which each month starts: (153*mp+2)/5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/ecd_in_if.sv -----
// Request channel carrying one epoch timestamp.
interface ecd_in_if import ecd_pkg::*; ();
    logic   valid;
    logic   ready;
    t_epoch epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ----- hdl/ecd_out_if.sv -----
// Result channel carrying one civil date and time of day.
interface ecd_out_if import ecd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_year   year;
    t_month  month;
    t_mday   day_of_month;
    t_hour   hour;
    t_minute minute;
    t_second second;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, output ready);
endinterface

// ----- hdl/epoch_to_civil_datetime.sv -----
// Throughput: one request per cycle unless every stage is full and output stalls.
// 14 pipeline stages, each holding one request; the last one drives the result.
// Each stage has its own valid bit, so bubbles close up and a waiting result does
// not stop new requests while an earlier stage is empty.
// Reset (synchronous, active low) clears the valid bits; payload is not reset.
module epoch_to_civil_datetime import ecd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ecd_in_if.sink           i_req,
    ecd_out_if.source        o_rsp
);

    localparam int NSTG = 14;

    // Pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_rdy;
    logic            w_in_acc;
    logic            w_out_acc;

    // A stage may load when some stage at or after it is free or the output drains
    for (genvar k = 0; k < NSTG; k++) begin : g_rdy
        assign w_rdy[k] = o_rsp.ready || !(&r_vld[NSTG-1:k]);
    end

    assign i_req.ready = w_rdy[0] && i_rst_n;
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_out_acc   = o_rsp.valid && o_rsp.ready;

    always_comb begin
        n_vld[0] = w_rdy[0] ? i_req.valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage registers
    t_epoch      r0_e;
    logic [33:0] r1_u;
    logic [6:0]  r1_lo7;
    logic [33:0] r2_u;
    logic [7:0]  r2_qh;
    logic [6:0]  r2_lo7;
    logic [26:0] r3_nl;
    logic [7:0]  r3_qh;
    logic [6:0]  r3_lo7;
    logic [26:0] r4_nl;
    logic [16:0] r4_ql;
    logic [7:0]  r4_qh;
    logic [6:0]  r4_lo7;
    logic [24:0] r5_z;
    logic [16:0] r5_sod;
    logic [24:0] r6_z;
    logic [16:0] r6_sod;
    logic [6:0]  r6_era;
    t_hour       r6_hr;
    logic [17:0] r7_doe;
    logic [11:0] r7_rsec;
    logic [6:0]  r7_era;
    t_hour       r7_hr;
    logic [17:0] r8_doe;
    logic [11:0] r8_rsec;
    logic [6:0]  r8_era;
    t_hour       r8_hr;
    logic [6:0]  r8_t1;
    logic [2:0]  r8_t2;
    logic        r8_t3;
    t_minute     r8_min;
    logic [17:0] r9_n;
    logic [17:0] r9_doe;
    logic [6:0]  r9_era;
    t_hour       r9_hr;
    t_minute     r9_min;
    t_second     r9_sec;
    logic [8:0]  r10_yoe;
    logic [17:0] r10_doe;
    logic [6:0]  r10_era;
    t_hour       r10_hr;
    t_minute     r10_min;
    t_second     r10_sec;
    logic [8:0]  r11_doy;
    logic [8:0]  r11_yoe;
    logic [6:0]  r11_era;
    t_hour       r11_hr;
    t_minute     r11_min;
    t_second     r11_sec;
    logic [3:0]  r12_mp;
    logic [8:0]  r12_doy;
    logic [8:0]  r12_yoe;
    logic [6:0]  r12_era;
    t_hour       r12_hr;
    t_minute     r12_min;
    t_second     r12_sec;
    t_year       r13_year;
    t_month      r13_month;
    t_mday       r13_mday;
    t_hour       r13_hr;
    t_minute     r13_min;
    t_second     r13_sec;

    // Next values and products
    logic [33:0] n_u;
    logic [34:0] w_qh_prod;
    logic [16:0] w_rh_full;
    logic [54:0] w_ql_prod;
    logic [26:0] w_rl_full;
    logic [24:0] n_z;
    logic [16:0] n_sod;
    logic [50:0] w_era_prod;
    logic [34:0] w_hr_prod;
    logic [24:0] w_doe_full;
    logic [16:0] w_rsec_full;
    logic [36:0] w_q4y_prod;
    logic [36:0] w_cen_prod;
    logic [24:0] w_min_prod;
    logic [17:0] n_n;
    logic [11:0] w_sec_full;
    logic [36:0] w_yr_prod;
    logic [17:0] w_y365;
    logic [18:0] w_c100_prod;
    logic [17:0] w_doy_full;
    logic [22:0] w_mp_prod;
    t_month      n_month;
    logic [8:0]  w_mday_full;
    logic [16:0] w_year_full;

    // Stage 1: floor(e / 128) plus a bias that keeps it positive
    assign n_u = {r0_e[39], r0_e[39:7]} + DAY_BIAS;

    // Stage 2: upper half of the day division
    assign w_qh_prod = 35'(r1_u[33:17]) * 35'(HI_DIV_MUL);

    // Stage 3: remainder of the upper half joins the lower half
    assign w_rh_full = r2_u[33:17] - 17'(r2_qh) * 17'(SEC_DAY_HI);

    // Stage 4: lower half of the day division
    assign w_ql_prod = 55'(r3_nl) * 55'(LO_DIV_MUL);

    // Stage 5: seconds of day and the biased day number
    assign w_rl_full = r4_nl - 27'(r4_ql) * 27'(SEC_DAY_HI);
    assign n_sod     = {w_rl_full[9:0], r4_lo7};
    assign n_z       = {r4_qh, r4_ql} + Z_BIAS;

    // Stage 6: era and hour
    assign w_era_prod = 51'(r5_z) * 51'(ERA_DIV_MUL);
    assign w_hr_prod  = 35'(r5_sod) * 35'(HR_DIV_MUL);

    // Stage 7: day of era and seconds within the hour
    assign w_doe_full  = r6_z - 25'(r6_era) * 25'(ERA_DAYS);
    assign w_rsec_full = r6_sod - 17'(r6_hr) * 17'(SEC_HOUR);

    // Stage 8: leap-day corrections and minute
    assign w_q4y_prod = 37'(r7_doe) * 37'(Q4Y_DIV_MUL);
    assign w_cen_prod = 37'(r7_doe) * 37'(CEN_DIV_MUL);
    assign w_min_prod = 25'(r7_rsec) * 25'(MIN_DIV_MUL);

    // Stage 9: leap-free day count and second
    assign n_n        = r8_doe - 18'(r8_t1) + 18'(r8_t2) - 18'(r8_t3);
    assign w_sec_full = r8_rsec - 12'(r8_min) * 12'(SEC_MIN);

    // Stage 10: year of era
    assign w_yr_prod = 37'(r9_n) * 37'(YR_DIV_MUL);

    // Stage 11: day of the March-based year
    assign w_y365      = 18'(r10_yoe) * 18'(YEAR_DAYS);
    assign w_c100_prod = 19'(r10_yoe) * 19'(C100_DIV_MUL);
    assign w_doy_full  = r10_doe - (w_y365 + 18'(r10_yoe[8:2])
                                    - 18'(w_c100_prod[18:C100_DIV_SH]));

    // Stage 12: March-based month
    assign w_mp_prod = (23'(r11_doy) * 23'd5 + 23'd2) * 23'(MP_DIV_MUL);

    // Stage 13: calendar month, day and year
    assign n_month     = (r12_mp < 4'd10) ? r12_mp + 4'd3 : r12_mp - 4'd9;
    assign w_mday_full = r12_doy - month_start(r12_mp) + 9'd1;
    assign w_year_full = 17'(r12_era) * 17'd400 + 17'(r12_yoe)
                       + 17'(n_month <= 4'd2) - YEAR_BIAS;

    // Payload registers, loaded whenever their stage advances
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_e <= i_req.epoch_seconds;
        end
        if (w_rdy[1]) begin
            r1_u   <= n_u;
            r1_lo7 <= r0_e[6:0];
        end
        if (w_rdy[2]) begin
            r2_u   <= r1_u;
            r2_qh  <= w_qh_prod[34:HI_DIV_SH];
            r2_lo7 <= r1_lo7;
        end
        if (w_rdy[3]) begin
            r3_nl  <= {w_rh_full[9:0], r2_u[16:0]};
            r3_qh  <= r2_qh;
            r3_lo7 <= r2_lo7;
        end
        if (w_rdy[4]) begin
            r4_nl  <= r3_nl;
            r4_ql  <= w_ql_prod[53:LO_DIV_SH];
            r4_qh  <= r3_qh;
            r4_lo7 <= r3_lo7;
        end
        if (w_rdy[5]) begin
            r5_z   <= n_z;
            r5_sod <= n_sod;
        end
        if (w_rdy[6]) begin
            r6_z   <= r5_z;
            r6_sod <= r5_sod;
            r6_era <= w_era_prod[49:ERA_DIV_SH];
            r6_hr  <= w_hr_prod[33:HR_DIV_SH];
        end
        if (w_rdy[7]) begin
            r7_doe  <= w_doe_full[17:0];
            r7_rsec <= w_rsec_full[11:0];
            r7_era  <= r6_era;
            r7_hr   <= r6_hr;
        end
        if (w_rdy[8]) begin
            r8_doe  <= r7_doe;
            r8_rsec <= r7_rsec;
            r8_era  <= r7_era;
            r8_hr   <= r7_hr;
            r8_t1   <= w_q4y_prod[35:Q4Y_DIV_SH];
            r8_t2   <= w_cen_prod[36:CEN_DIV_SH];
            r8_t3   <= (r7_doe == 18'(ERA_DAYS - 1));
            r8_min  <= w_min_prod[23:MIN_DIV_SH];
        end
        if (w_rdy[9]) begin
            r9_n   <= n_n;
            r9_doe <= r8_doe;
            r9_era <= r8_era;
            r9_hr  <= r8_hr;
            r9_min <= r8_min;
            r9_sec <= w_sec_full[5:0];
        end
        if (w_rdy[10]) begin
            r10_yoe <= w_yr_prod[35:YR_DIV_SH];
            r10_doe <= r9_doe;
            r10_era <= r9_era;
            r10_hr  <= r9_hr;
            r10_min <= r9_min;
            r10_sec <= r9_sec;
        end
        if (w_rdy[11]) begin
            r11_doy <= w_doy_full[8:0];
            r11_yoe <= r10_yoe;
            r11_era <= r10_era;
            r11_hr  <= r10_hr;
            r11_min <= r10_min;
            r11_sec <= r10_sec;
        end
        if (w_rdy[12]) begin
            r12_mp  <= w_mp_prod[22:MP_DIV_SH];
            r12_doy <= r11_doy;
            r12_yoe <= r11_yoe;
            r12_era <= r11_era;
            r12_hr  <= r11_hr;
            r12_min <= r11_min;
            r12_sec <= r11_sec;
        end
        if (w_rdy[13]) begin
            r13_year  <= w_year_full[15:0];
            r13_month <= n_month;
            r13_mday  <= w_mday_full[4:0];
            r13_hr    <= r12_hr;
            r13_min   <= r12_min;
            r13_sec   <= r12_sec;
        end
    end

    // Result port
    assign o_rsp.valid        = r_vld[NSTG-1];
    assign o_rsp.year         = r13_year;
    assign o_rsp.month        = r13_month;
    assign o_rsp.day_of_month = r13_mday;
    assign o_rsp.hour         = r13_hr;
    assign o_rsp.minute       = r13_min;
    assign o_rsp.second       = r13_sec;

    // Requests in flight change only by what enters and what leaves
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> ($countones(r_vld) == $countones($past(r_vld))
                     + int'($past(w_in_acc)) - int'($past(w_out_acc))))
        else $error("pipeline occupancy mismatch");

    // Seconds-of-day split stays in range
    a_sod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r5_sod < 17'd86400))
        else $error("seconds of day out of range");

    // Era remainder and seconds within the hour stay in range
    a_doe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> (r7_doe < 18'(ERA_DAYS)) && (r7_rsec < 12'(SEC_HOUR)))
        else $error("day of era or seconds of hour out of range");

    // Every presented result has month 1 to 12, a day of at least 1 and a legal time of day
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.month >= 4'd1) && (o_rsp.month <= 4'd12)
                     && (o_rsp.day_of_month >= 5'd1) && (o_rsp.hour <= 5'd23)
                     && (o_rsp.minute <= 6'd59) && (o_rsp.second <= 6'd59))
        else $error("result field out of range");

endmodule

// ----- dv/tb_epoch_to_civil_datetime.sv -----
// Testbench for the epoch seconds to civil date and time-of-day converter.
module tb_epoch_to_civil_datetime;
    timeunit 1ns;
    timeprecision 1ps;

    import ecd_pkg::*;

    // Calendar arithmetic constants, kept signed for the date predictor
    localparam longint DAY_SECS     = 86400;
    localparam longint HOUR_SECS    = 3600;
    localparam longint MINUTE_SECS  = 60;
    localparam longint MARCH_SHIFT  = 719468;   // 0000-03-01 back from 1970-01-01
    localparam longint CYCLE_DAYS   = 146097;   // days in a 400-year cycle
    localparam longint CYCLE_LAST   = 146096;
    localparam longint QUAD_DAYS    = 1460;
    localparam longint CENTURY_DAYS = 36524;
    localparam longint COMMON_DAYS  = 365;
    localparam longint MONTH_SPAN   = 153;

    localparam int PIPE_LATENCY = 13;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        t_year   year;
        t_month  month;
        t_mday   day_of_month;
        t_hour   hour;
        t_minute minute;
        t_second second;
    } t_civil;

    logic i_clk;
    logic i_rst_n;

    ecd_in_if  req_if ();
    ecd_out_if rsp_if ();

    epoch_to_civil_datetime i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_civil pending_dates[$];
    int     mismatches  = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     stall_pct     = 0;
    int     hold_left     = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Expected civil date/time for one epoch value (floor split, then 400-year cycles)
    function automatic t_civil epoch_to_civil(input t_epoch epoch);
        longint secs, days, sod, z, cyc, doe, yoe, doy, mp, dd, mm, yy;
        t_civil r;
        secs = longint'(epoch);
        days = secs / DAY_SECS;
        sod  = secs % DAY_SECS;
        // negative epochs: floor the day, keep seconds-of-day non-negative
        if (sod < 0) begin
            sod  += DAY_SECS;
            days -= 1;
        end
        z   = days + MARCH_SHIFT;
        cyc = (z >= 0 ? z : z - CYCLE_LAST) / CYCLE_DAYS;
        doe = z - cyc * CYCLE_DAYS;
        yoe = (doe - doe / QUAD_DAYS + doe / CENTURY_DAYS - doe / CYCLE_LAST) / COMMON_DAYS;
        doy = doe - (COMMON_DAYS * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / MONTH_SPAN;
        dd  = doy - (MONTH_SPAN * mp + 2) / 5 + 1;
        mm  = (mp < 10) ? mp + 3 : mp - 9;
        yy  = yoe + cyc * 400;
        if (mm <= 2)
            yy += 1;
        r.year         = t_year'(yy);
        r.month        = t_month'(mm);
        r.day_of_month = t_mday'(dd);
        r.hour         = t_hour'(sod / HOUR_SECS);
        r.minute       = t_minute'((sod % HOUR_SECS) / MINUTE_SECS);
        r.second       = t_second'(sod % MINUTE_SECS);
        return r;
    endfunction

    // Random timestamp: full range, near the epoch, day edges, 400-year edges
    function automatic t_epoch rand_epoch();
        longint v, days;
        case ($urandom_range(3))
            0: v = {$urandom, $urandom};
            1: v = longint'($signed($urandom));
            2: begin
                days = longint'($urandom_range(12725000)) - 6362500;
                v    = days * DAY_SECS + longint'($urandom_range(2)) - 1;
            end
            default: begin
                days = (longint'($urandom_range(86)) - 38) * CYCLE_DAYS - MARCH_SHIFT
                       + longint'($urandom_range(2)) - 1;
                v    = days * DAY_SECS + longint'($urandom_range(86399));
            end
        endcase
        return t_epoch'(v);
    endfunction

    // Send one request, with random idle cycles ahead of it
    task automatic send_epoch(input t_epoch epoch);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_if.valid         <= 1'b1;
        req_if.epoch_seconds <= epoch;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pending_dates.push_back(epoch_to_civil(epoch));
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge i_clk);
    endtask

    // Result ready: random stalls, or a counted hold-off when requested
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_civil want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_dates.size() == 0) begin
                $error("result with no request outstanding: year %0d",
                       $signed(rsp_if.year));
                mismatches++;
            end else begin
                want = pending_dates.pop_front();
                check_field("year", $signed(want.year), $signed(rsp_if.year));
                check_field("month", want.month, rsp_if.month);
                check_field("day_of_month", want.day_of_month, rsp_if.day_of_month);
                check_field("hour", want.hour, rsp_if.hour);
                check_field("minute", want.minute, rsp_if.minute);
                check_field("second", want.second, rsp_if.second);
            end
        end
    end

    // Edges of the range, sign, day/year/leap boundaries, bit patterns
    task automatic test_directed();
        longint stamps[] = '{
            0, 1, -1, 59, 3599, 3600, 86399, 86400, -86400, -86401,
            946684799, 946684800,           // end of 1999, start of 2000
            951782400, 951868799, 951868800, // leap day in a 400-year year
            64'sd4107456000, 64'sd4107542400, // around March 1 of a non-leap century
            -64'sd62162035200, -64'sd62162035201, // March 1 of year zero and the day before
            -64'sd62167219200,              // January 1 of year zero
            64'sd549755813887, -64'sd549755813888, // input extremes
            64'h55_5555_5555, 64'hAA_AAAA_AAAA
        };
        send_idle_pct = 0;
        stall_pct     = 0;
        foreach (stamps[i])
            send_epoch(t_epoch'(stamps[i]));
        wait_drained();
    endtask

    // Random stream under one idle/stall setting
    task automatic test_random_stream(input int idle_pct, input int stall, input int count);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count)
            send_epoch(rand_epoch());
        wait_drained();
    endtask

    // Long receiver hold-off while requests keep coming, so the pipe fills
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 200;
        repeat (40)
            send_epoch(rand_epoch());
        wait_drained();
    endtask

    initial begin
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.epoch_seconds = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_stream(0, 0, 100);
        test_random_stream(70, 0, 100);
        test_random_stream(0, 70, 100);
        test_random_stream(12, 12, 100);
        test_backpressure();

        repeat (PIPE_LATENCY + 7) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
